>>> rtl/core/modular_arithmetic_unit_macros.svh
// assertion macros for the modular arithmetic unit
// used by files that hold concurrent assertions; expects clk and rst in scope
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mau_pkg.sv
// shared types, codes and modular add/subtract helpers for the modular arithmetic unit
// no dependencies
`default_nettype none

package mau_pkg;

  localparam int WORD_WIDTH_DEFAULT = 64;
  localparam int MAX_WIDTH = 64;

  localparam logic [2:0] CMD_MUL = 3'd0;
  localparam logic [2:0] CMD_MAC = 3'd1;
  localparam logic [2:0] CMD_ADD = 3'd2;
  localparam logic [2:0] CMD_SUB = 3'd3;
  localparam logic [2:0] CMD_POW = 3'd4;
  localparam logic [2:0] CMD_INV = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_RED_C,
    ST_DISPATCH,
    ST_MUL,
    ST_POW_NORM,
    ST_POW_NEXT,
    ST_POW_SQ,
    ST_POW_ML,
    ST_INV_CHK,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_DONE
  } mau_state_t;

  // x, y below m
  function automatic logic [MAX_WIDTH-1:0] mod_add(input logic [MAX_WIDTH-1:0] x,
                                                   input logic [MAX_WIDTH-1:0] y,
                                                   input logic [MAX_WIDTH-1:0] m);
    logic [MAX_WIDTH-1:0] c;
    c = m - y;
    if (x >= c) begin
      return x - c;
    end
    return x + y;
  endfunction

  // x, y below m
  function automatic logic [MAX_WIDTH-1:0] mod_sub(input logic [MAX_WIDTH-1:0] x,
                                                   input logic [MAX_WIDTH-1:0] y,
                                                   input logic [MAX_WIDTH-1:0] m);
    if (x >= y) begin
      return x - y;
    end
    return m - (y - x);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mau_divider.sv
// restoring divider, one quotient bit per cycle
// depends on nothing but its ports
`default_nettype none

module mau_divider #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  d_r;
  logic [W:0]    trial;
  logic          take;

  assign trial = {rem, quo[W-1]};
  assign take  = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(W-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      quo <= num;
      d_r <= den;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      rem <= take ? W'(trial - {1'b0, d_r}) : trial[W-1:0];
      quo <= {quo[W-2:0], take};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mau_mulmod.sv
// double-and-add modular multiplier, one bit of y per doubling and conditional add
// depends on mau_pkg for the modular add
`default_nettype none

module mau_mulmod #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] x,
  input  wire logic [W-1:0] y,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      prod
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic          phase;
  logic [CW-1:0] cnt;
  logic [W-1:0]  x_r;
  logic [W-1:0]  y_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  addend;
  logic [W-1:0]  sum;

  // phase 0 doubles, phase 1 adds x when the current bit is set
  assign addend = phase ? x_r : prod;
  assign sum = W'(mau_pkg::mod_add(mau_pkg::MAX_WIDTH'(prod), mau_pkg::MAX_WIDTH'(addend),
                                   mau_pkg::MAX_WIDTH'(m_r)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && phase && cnt == CW'(W-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      phase <= 1'b0;
      cnt   <= '0;
      prod  <= '0;
      x_r   <= x;
      y_r   <= y;
      m_r   <= m;
    end else if (busy) begin
      phase <= ~phase;
      if (!phase || y_r[W-1]) begin
        prod <= sum;
      end
      if (phase) begin
        y_r <= {y_r[W-2:0], 1'b0};
        cnt <= cnt + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/modular_arithmetic_unit.sv
// modular arithmetic unit top level: apb register, sequencer and result register
// depends on mau_pkg, mau_divider, mau_mulmod and modular_arithmetic_unit_macros.svh
`default_nettype none
`include "modular_arithmetic_unit_macros.svh"

// One item at a time: an accepted beat first has its three operands reduced
// mod m by a restoring divider, then runs its command. mul and mac take one
// double-and-add multiplication; add and sub are computed in the dispatch
// state; pow takes up to 2(W-1) multiplications; inverse takes one division
// and one multiplication per Euclid step. in_stall is high from acceptance
// until the result has moved into the output register, which holds it until
// taken. Only the low WORD_WIDTH bits of the 64-bit modulus register are
// used; m below two gives 0.
module modular_arithmetic_unit #(
  parameter int WORD_WIDTH = mau_pkg::WORD_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [63:0]           pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            command,
  input  wire logic [WORD_WIDTH-1:0] operand_a,
  input  wire logic [WORD_WIDTH-1:0] operand_b,
  input  wire logic [WORD_WIDTH-1:0] operand_c,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WORD_WIDTH-1:0]      result
);

  localparam int W  = WORD_WIDTH;
  localparam int PW = $clog2(W);

  // register file: one 64-bit register at byte address 0
  logic [63:0] modulus;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= 64'd2;
    end else if (psel && penable && pwrite && !paddr[3]) begin
      modulus <= pwdata;
    end
  end

  mau_pkg::mau_state_t state, state_next;
  logic          kick;

  // item registers
  logic [2:0]    cmd_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  c_r;
  logic [W-1:0]  e_r;
  logic [PW-1:0] pcnt;
  logic [W-1:0]  pr;
  // euclid registers
  logic [W-1:0]  r0;
  logic [W-1:0]  s0;
  logic [W-1:0]  s1;
  logic [W-1:0]  ix;
  logic [W-1:0]  q_r;
  logic [W-1:0]  rm_r;
  logic [W-1:0]  res_r;

  // shared units
  logic          div_start, div_done;
  logic [W-1:0]  div_num, div_den, div_quo, div_rem;
  logic          mul_start, mul_done;
  logic [W-1:0]  mul_x, mul_y, mul_prod;

  logic          accept;
  logic          m_small;
  logic          cmd_bad;
  logic          out_free;

  assign in_stall = (state != mau_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign m_small  = (m_r < W'(2));
  assign cmd_bad  = (cmd_r > mau_pkg::CMD_INV);
  assign out_free = !out_valid || !out_stall;

  mau_divider #(.W(W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  mau_mulmod #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (m_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // unit operand select by state; a unit starts on the first cycle of its state
  always_comb begin
    div_num   = a_r;
    div_den   = m_r;
    div_start = 1'b0;
    mul_x     = a_r;
    mul_y     = b_r;
    mul_start = 1'b0;
    case (state)
      mau_pkg::ST_RED_A: begin
        div_start = kick;
      end
      mau_pkg::ST_RED_B: begin
        div_num   = e_r;
        div_start = kick;
      end
      mau_pkg::ST_RED_C: begin
        div_num   = c_r;
        div_start = kick;
      end
      mau_pkg::ST_INV_DIV: begin
        div_num   = r0;
        div_den   = ix;
        div_start = kick;
      end
      mau_pkg::ST_MUL: begin
        mul_start = kick;
      end
      mau_pkg::ST_POW_SQ: begin
        mul_x     = pr;
        mul_y     = pr;
        mul_start = kick;
      end
      mau_pkg::ST_POW_ML: begin
        // multiply the running power by the reduced base
        mul_x     = pr;
        mul_y     = a_r;
        mul_start = kick;
      end
      mau_pkg::ST_INV_MUL: begin
        mul_x     = s1;
        mul_y     = q_r;
        mul_start = kick;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      mau_pkg::ST_IDLE: begin
        if (accept) state_next = mau_pkg::ST_RED_A;
      end
      mau_pkg::ST_RED_A: begin
        if (div_done) state_next = mau_pkg::ST_RED_B;
      end
      mau_pkg::ST_RED_B: begin
        if (div_done) state_next = mau_pkg::ST_RED_C;
      end
      mau_pkg::ST_RED_C: begin
        if (div_done) state_next = mau_pkg::ST_DISPATCH;
      end
      mau_pkg::ST_DISPATCH: begin
        if (m_small || cmd_bad) begin
          state_next = mau_pkg::ST_DONE;
        end else begin
          case (cmd_r)
            mau_pkg::CMD_MUL, mau_pkg::CMD_MAC: state_next = mau_pkg::ST_MUL;
            mau_pkg::CMD_POW: begin
              state_next = (e_r == '0) ? mau_pkg::ST_DONE : mau_pkg::ST_POW_NORM;
            end
            mau_pkg::CMD_INV: state_next = mau_pkg::ST_INV_CHK;
            default: state_next = mau_pkg::ST_DONE;
          endcase
        end
      end
      mau_pkg::ST_MUL: begin
        if (mul_done) state_next = mau_pkg::ST_DONE;
      end
      mau_pkg::ST_POW_NORM: begin
        if (e_r[W-1]) state_next = mau_pkg::ST_POW_NEXT;
      end
      mau_pkg::ST_POW_NEXT: begin
        state_next = (pcnt == '0) ? mau_pkg::ST_DONE : mau_pkg::ST_POW_SQ;
      end
      mau_pkg::ST_POW_SQ: begin
        if (mul_done) state_next = e_r[W-1] ? mau_pkg::ST_POW_ML : mau_pkg::ST_POW_NEXT;
      end
      mau_pkg::ST_POW_ML: begin
        if (mul_done) state_next = mau_pkg::ST_POW_NEXT;
      end
      mau_pkg::ST_INV_CHK: begin
        state_next = (ix > W'(1)) ? mau_pkg::ST_INV_DIV : mau_pkg::ST_DONE;
      end
      mau_pkg::ST_INV_DIV: begin
        if (div_done) state_next = mau_pkg::ST_INV_MUL;
      end
      mau_pkg::ST_INV_MUL: begin
        if (mul_done) state_next = mau_pkg::ST_INV_CHK;
      end
      mau_pkg::ST_DONE: begin
        if (out_free) state_next = mau_pkg::ST_IDLE;
      end
      default: state_next = mau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mau_pkg::ST_IDLE;
      kick      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kick  <= (state_next != state);
      if (state == mau_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mau_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_r <= command;
          m_r   <= modulus[W-1:0];
          a_r   <= operand_a;
          e_r   <= operand_b;
          c_r   <= operand_c;
        end
      end
      mau_pkg::ST_RED_A: begin
        if (div_done) a_r <= div_rem;
      end
      mau_pkg::ST_RED_B: begin
        if (div_done) b_r <= div_rem;
      end
      mau_pkg::ST_RED_C: begin
        if (div_done) c_r <= div_rem;
      end
      mau_pkg::ST_DISPATCH: begin
        res_r <= '0;
        pr    <= a_r;
        pcnt  <= PW'(W-1);
        ix    <= a_r;
        r0    <= m_r;
        s0    <= '0;
        s1    <= W'(1);
        case (cmd_r)
          mau_pkg::CMD_ADD: begin
            res_r <= W'(mau_pkg::mod_add(mau_pkg::MAX_WIDTH'(a_r), mau_pkg::MAX_WIDTH'(b_r),
                                         mau_pkg::MAX_WIDTH'(m_r)));
          end
          mau_pkg::CMD_SUB: begin
            res_r <= W'(mau_pkg::mod_sub(mau_pkg::MAX_WIDTH'(a_r), mau_pkg::MAX_WIDTH'(b_r),
                                         mau_pkg::MAX_WIDTH'(m_r)));
          end
          mau_pkg::CMD_POW: begin
            res_r <= W'(1);
          end
          default: begin
          end
        endcase
        if (m_small) res_r <= '0;
      end
      mau_pkg::ST_MUL: begin
        if (mul_done) begin
          if (cmd_r == mau_pkg::CMD_MAC) begin
            res_r <= W'(mau_pkg::mod_add(mau_pkg::MAX_WIDTH'(c_r),
                                         mau_pkg::MAX_WIDTH'(mul_prod),
                                         mau_pkg::MAX_WIDTH'(m_r)));
          end else begin
            res_r <= mul_prod;
          end
        end
      end
      mau_pkg::ST_POW_NORM: begin
        // shift up to the leading one, then drop it
        e_r <= {e_r[W-2:0], 1'b0};
        if (!e_r[W-1]) pcnt <= pcnt - PW'(1);
      end
      mau_pkg::ST_POW_NEXT: begin
        res_r <= pr;
      end
      mau_pkg::ST_POW_SQ: begin
        if (mul_done) begin
          pr <= mul_prod;
          if (!e_r[W-1]) begin
            e_r  <= {e_r[W-2:0], 1'b0};
            pcnt <= pcnt - PW'(1);
          end
        end
      end
      mau_pkg::ST_POW_ML: begin
        if (mul_done) begin
          pr   <= mul_prod;
          e_r  <= {e_r[W-2:0], 1'b0};
          pcnt <= pcnt - PW'(1);
        end
      end
      mau_pkg::ST_INV_CHK: begin
        res_r <= s1;
      end
      mau_pkg::ST_INV_DIV: begin
        if (div_done) begin
          q_r  <= div_quo;
          rm_r <= div_rem;
        end
      end
      mau_pkg::ST_INV_MUL: begin
        if (mul_done) begin
          s1 <= W'(mau_pkg::mod_sub(mau_pkg::MAX_WIDTH'(s0), mau_pkg::MAX_WIDTH'(mul_prod),
                                    mau_pkg::MAX_WIDTH'(m_r)));
          s0 <= s1;
          r0 <= ix;
          ix <= rm_r;
        end
      end
      mau_pkg::ST_DONE: begin
        if (out_free) result <= res_r;
      end
      default: begin
      end
    endcase
  end

  // results of a live modulus stay below it
  `MAU_ASSERT_SAME(a_res_range, state == mau_pkg::ST_DONE && !m_small, res_r < m_r,
                   "result not reduced below modulus")
  // an accepted beat always leaves idle
  `MAU_ASSERT_NEXT(a_accept_busy, accept, state != mau_pkg::ST_IDLE,
                   "sequencer stayed idle after accept")
  // no unit can finish in the cycle after it starts
  `MAU_ASSERT_NEXT(a_mul_latency, mul_start, !mul_done, "multiplier done too early")
  `MAU_ASSERT_NEXT(a_div_latency, div_start, !div_done, "divider done too early")

endmodule

`default_nettype wire
